// ===== src/ssr_pkg.sv =====
// Package for the segmented sort and reorder block.
// Holds the field widths, the item kind codes, the parameter defaults and the sequencer states.
`timescale 1ns / 1ps
package ssr_pkg;

    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int MAX_SEGMENTS_DEF = 64;

    localparam int ID_W  = 6;
    localparam int LEN_W = 11;
    localparam int VAL_W = 64;
    localparam int CFG_W = 7;
    localparam int KIND_W = 2;

    localparam logic [KIND_W-1:0] KIND_DESC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ELEM = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OFF_K,
        ST_OFF_KW,
        ST_OFF_Q,
        ST_OFF_QW,
        ST_SRT_K,
        ST_SRT_KW,
        ST_SRT_I,
        ST_SRT_IW,
        ST_SRT_J,
        ST_SRT_JW,
        ST_RD_K,
        ST_RD_KW,
        ST_RD_EW,
        ST_RSP
    } t_state;

endpackage

// ===== src/ssr_ram.sv =====
// Generic simple dual port RAM with one write port and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
module ssr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/segmented_sort_reorder_core.sv =====
// Top level of the segmented sort and reorder block.
// Depends on ssr_pkg and on ssr_ram for the element, descriptor and offset memories.
`timescale 1ns / 1ps
// The block takes descriptor words (segment id and length), then element words, sorts
// every segment in place in ascending signed order and answers read words with the
// segments in ascending id order, one value per read. After the last descriptor the
// output offsets are worked out by a scan of the descriptor memory. After the last
// element each segment is insertion sorted through the single port pair of the
// element memory: each element is read as the key, and the larger elements before it
// are shifted up one place until its place is found. A read word scans the segments
// in turn until it finds its own, then reads its element. The input is not ready while
// any of this runs. A result waits in an output register and does not stop the next word
// from being taken. A configuration write sets the segment count and clears the counts,
// but it leaves the sequencer state as it is.
module segmented_sort_reorder_core
    import ssr_pkg::*;
#(
    parameter int MAX_ELEMENTS = ssr_pkg::MAX_ELEMENTS_DEF,
    parameter int MAX_SEGMENTS = ssr_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [ssr_pkg::CFG_W-1:0] i_cfg_data,   // segment_count
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [87:0]               i_s_tdata,    // seg_id[5:0], seg_len[16:6], value[80:17]
    input  logic [ssr_pkg::KIND_W-1:0] i_s_tuser,   // kind
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [63:0]               o_m_tdata,    // out_value
    output logic                      o_m_tlast,    // out_last
    output logic [0:0]                o_m_tuser     // out_valid
);

    localparam int AW  = $clog2(MAX_ELEMENTS);
    localparam int CW  = $clog2(MAX_ELEMENTS + 1);
    localparam int SAW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int SCW = $clog2(MAX_SEGMENTS + 1);
    localparam int DW  = ID_W + 2 * CW;

    // Input fields.
    logic [ID_W-1:0]   w_id;
    logic [LEN_W-1:0]  w_len;
    logic [VAL_W-1:0]  w_val;
    logic              w_acc;
    assign w_id  = i_s_tdata[5:0];
    assign w_len = i_s_tdata[16:6];
    assign w_val = i_s_tdata[80:17];

    // Run state.
    t_state         r_state, n_state;
    logic [SCW-1:0] r_eff, n_eff;
    logic [SCW-1:0] r_desc, n_desc;
    logic [CW-1:0]  r_total, n_total;
    logic [CW-1:0]  r_elem, n_elem;
    logic [CW-1:0]  r_rpos, n_rpos;
    logic [SCW-1:0] r_k, n_k;
    logic [SCW-1:0] r_q, n_q;
    logic [CW-1:0]  r_off, n_off;
    logic [ID_W-1:0] r_idk, n_idk;
    logic [CW-1:0]  r_start, n_start;
    logic [CW-1:0]  r_len, n_len;
    logic [CW-1:0]  r_i, n_i;
    logic [CW-1:0]  r_j, n_j;
    logic [VAL_W-1:0] r_key, n_key;
    logic           r_mval, n_mval;
    logic [VAL_W-1:0] r_rval, n_rval;
    logic           r_rlast, n_rlast;
    logic           r_rflag, n_rflag;

    // Memory ports.
    logic            e_we;
    logic [AW-1:0]   e_waddr, e_raddr;
    logic [VAL_W-1:0] e_wdata, e_rdata;
    logic            d_we;
    logic [SAW-1:0]  d_waddr, d_raddr;
    logic [DW-1:0]   d_wdata, d_rdata;
    logic            o_we;
    logic [SAW-1:0]  o_waddr;
    logic [CW-1:0]   o_wdata, o_rdata;

    logic [ID_W-1:0] d_id;
    logic [CW-1:0]   d_len, d_ioff;
    assign d_id   = d_rdata[ID_W-1:0];
    assign d_len  = d_rdata[ID_W +: CW];
    assign d_ioff = d_rdata[ID_W+CW +: CW];

    ssr_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ELEMENTS), .AW(AW)) u_elem (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_waddr), .i_wdata(e_wdata),
        .i_raddr(e_raddr), .o_rdata(e_rdata)
    );

    ssr_ram #(.WIDTH(DW), .DEPTH(MAX_SEGMENTS), .AW(SAW)) u_desc (
        .i_clk(i_clk), .i_we(d_we), .i_waddr(d_waddr), .i_wdata(d_wdata),
        .i_raddr(d_raddr), .o_rdata(d_rdata)
    );

    ssr_ram #(.WIDTH(CW), .DEPTH(MAX_SEGMENTS), .AW(SAW)) u_ooff (
        .i_clk(i_clk), .i_we(o_we), .i_waddr(o_waddr), .i_wdata(o_wdata),
        .i_raddr(r_k[SAW-1:0]), .o_rdata(o_rdata)
    );

    logic w_desc_done, w_load_done;
    assign w_desc_done = (r_desc >= r_eff);
    assign w_load_done = w_desc_done && (r_elem >= r_total);

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_acc       = i_s_tvalid && o_s_tready;

    // Descriptor length, clamped so the running total stays within the store.
    logic [CW-1:0] w_room, w_lenc;
    assign w_room = CW'(MAX_ELEMENTS) - r_total;
    assign w_lenc = (32'(w_len) > 32'(w_room)) ? w_room : CW'(w_len);

    // Read lookup of the segment that holds the read position.
    logic          w_hit;
    logic [CW-1:0] w_rel;
    assign w_rel = r_rpos - o_rdata;
    assign w_hit = (r_rpos >= o_rdata) && (w_rel < d_len);

    // Output offset step: does descriptor q come before descriptor k.
    logic w_before;
    assign w_before = (d_id < r_idk) || ((d_id == r_idk) && (r_q < r_k));

    always_comb begin
        n_state = r_state;
        n_eff   = r_eff;
        n_desc  = r_desc;
        n_total = r_total;
        n_elem  = r_elem;
        n_rpos  = r_rpos;
        n_k     = r_k;
        n_q     = r_q;
        n_off   = r_off;
        n_idk   = r_idk;
        n_start = r_start;
        n_len   = r_len;
        n_i     = r_i;
        n_j     = r_j;
        n_key   = r_key;
        n_mval  = r_mval;
        n_rval  = r_rval;
        n_rlast = r_rlast;
        n_rflag = r_rflag;
        e_we    = 1'b0;
        e_waddr = '0;
        e_wdata = r_key;
        e_raddr = '0;
        d_we    = 1'b0;
        d_waddr = r_desc[SAW-1:0];
        d_wdata = {r_total, w_lenc, w_id};
        d_raddr = r_k[SAW-1:0];
        o_we    = 1'b0;
        o_waddr = r_k[SAW-1:0];
        o_wdata = r_off;

        if (r_mval && i_m_tready) begin
            n_mval = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    case (i_s_tuser)
                        KIND_DESC: begin
                            if (!w_desc_done) begin
                                d_we    = 1'b1;
                                n_total = r_total + w_lenc;
                                n_desc  = r_desc + 1'b1;
                                if (r_desc + 1'b1 == r_eff) begin
                                    n_state = ST_OFF_K;
                                    n_k     = '0;
                                end
                            end
                        end
                        KIND_ELEM: begin
                            if (w_desc_done && (r_elem < r_total)) begin
                                e_we    = 1'b1;
                                e_waddr = r_elem[AW-1:0];
                                e_wdata = w_val;
                                n_elem  = r_elem + 1'b1;
                                if (r_elem + 1'b1 == r_total) begin
                                    n_state = ST_SRT_K;
                                    n_k     = '0;
                                end
                            end
                        end
                        KIND_READ: begin
                            if (w_load_done && (r_rpos < r_total)) begin
                                n_state = ST_RD_K;
                                n_k     = '0;
                            end else begin
                                n_rval  = '0;
                                n_rlast = 1'b0;
                                n_rflag = 1'b0;
                                n_state = ST_RSP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_OFF_K: begin
                n_state = ST_OFF_KW;
            end
            ST_OFF_KW: begin
                n_idk   = d_id;
                n_q     = '0;
                n_off   = '0;
                n_state = ST_OFF_Q;
            end
            ST_OFF_Q: begin
                d_raddr = r_q[SAW-1:0];
                n_state = ST_OFF_QW;
            end
            ST_OFF_QW: begin
                n_off = w_before ? (r_off + d_len) : r_off;
                n_q   = r_q + 1'b1;
                if (r_q + 1'b1 == r_desc) begin
                    o_we    = 1'b1;
                    o_wdata = n_off;
                    n_k     = r_k + 1'b1;
                    n_state = (r_k + 1'b1 == r_desc) ? ST_IDLE : ST_OFF_K;
                end else begin
                    n_state = ST_OFF_Q;
                end
            end
            ST_SRT_K: begin
                n_state = ST_SRT_KW;
            end
            ST_SRT_KW: begin
                n_start = d_ioff;
                n_len   = d_len;
                n_i     = CW'(1);
                if (d_len <= CW'(1)) begin
                    n_k     = r_k + 1'b1;
                    n_state = (r_k + 1'b1 == r_desc) ? ST_IDLE : ST_SRT_K;
                end else begin
                    n_state = ST_SRT_I;
                end
            end
            ST_SRT_I: begin
                e_raddr = AW'(r_start + r_i);
                n_state = ST_SRT_IW;
            end
            ST_SRT_IW: begin
                n_key   = e_rdata;
                n_j     = r_i;
                n_state = ST_SRT_J;
            end
            ST_SRT_J: begin
                if (r_j == '0) begin
                    // Key is the smallest so far: it goes to the head of the segment.
                    e_we    = 1'b1;
                    e_waddr = AW'(r_start);
                    e_wdata = r_key;
                    n_i     = r_i + 1'b1;
                    if (r_i + 1'b1 == r_len) begin
                        n_k     = r_k + 1'b1;
                        n_state = (r_k + 1'b1 == r_desc) ? ST_IDLE : ST_SRT_K;
                    end else begin
                        n_state = ST_SRT_I;
                    end
                end else begin
                    e_raddr = AW'(r_start + r_j - 1'b1);
                    n_state = ST_SRT_JW;
                end
            end
            ST_SRT_JW: begin
                e_we    = 1'b1;
                e_waddr = AW'(r_start + r_j);
                if ($signed(r_key) < $signed(e_rdata)) begin
                    e_wdata = e_rdata;
                    n_j     = r_j - 1'b1;
                    n_state = ST_SRT_J;
                end else begin
                    e_wdata = r_key;
                    n_i     = r_i + 1'b1;
                    if (r_i + 1'b1 == r_len) begin
                        n_k     = r_k + 1'b1;
                        n_state = (r_k + 1'b1 == r_desc) ? ST_IDLE : ST_SRT_K;
                    end else begin
                        n_state = ST_SRT_I;
                    end
                end
            end
            ST_RD_K: begin
                n_state = ST_RD_KW;
            end
            ST_RD_KW: begin
                if (w_hit) begin
                    e_raddr = AW'(d_ioff + w_rel);
                    n_state = ST_RD_EW;
                end else if (r_k + 1'b1 == r_desc) begin
                    n_rval  = '0;
                    n_rlast = (r_rpos == r_total - 1'b1);
                    n_rflag = 1'b1;
                    n_state = ST_RSP;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = ST_RD_K;
                end
            end
            ST_RD_EW: begin
                n_rval  = e_rdata;
                n_rlast = (r_rpos == r_total - 1'b1);
                n_rflag = 1'b1;
                n_state = ST_RSP;
            end
            ST_RSP: begin
                // Wait for the output register to be free, then hand the word over.
                if (!r_mval || i_m_tready) begin
                    n_mval  = 1'b1;
                    n_state = ST_IDLE;
                    if (r_rflag) begin
                        n_rpos = r_rpos + 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // A configuration write sets the segment count and clears the run counts; the state register is left as it is.
        if (i_cfg_valid) begin
            if (i_cfg_data == '0) begin
                n_eff = SCW'(1);
            end else if (32'(i_cfg_data) > 32'(MAX_SEGMENTS)) begin
                n_eff = SCW'(MAX_SEGMENTS);
            end else begin
                n_eff = SCW'(i_cfg_data);
            end
            n_desc  = '0;
            n_elem  = '0;
            n_rpos  = '0;
            n_total = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_eff   <= SCW'(1);
            r_desc  <= '0;
            r_total <= '0;
            r_elem  <= '0;
            r_rpos  <= '0;
            r_k     <= '0;
            r_q     <= '0;
            r_mval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_eff   <= n_eff;
            r_desc  <= n_desc;
            r_total <= n_total;
            r_elem  <= n_elem;
            r_rpos  <= n_rpos;
            r_k     <= n_k;
            r_q     <= n_q;
            r_mval  <= n_mval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_off   <= n_off;
        r_idk   <= n_idk;
        r_start <= n_start;
        r_len   <= n_len;
        r_i     <= n_i;
        r_j     <= n_j;
        r_key   <= n_key;
        r_rval  <= n_rval;
        r_rlast <= n_rlast;
        r_rflag <= n_rflag;
    end

    // The result fields are copied into these output registers when the word is handed over;
    // a new read cannot overwrite them before its own RSP state, which waits for the slot.
    logic [VAL_W-1:0] r_oval;
    logic             r_olast;
    logic             r_oflag;
    always_ff @(posedge i_clk) begin
        if (r_state == ST_RSP && (!r_mval || i_m_tready)) begin
            r_oval  <= r_rval;
            r_olast <= r_rlast;
            r_oflag <= r_rflag;
        end
    end

    assign o_m_tvalid   = r_mval;
    assign o_m_tdata    = r_oval;
    assign o_m_tlast    = r_olast;
    assign o_m_tuser[0] = r_oflag;

endmodule
